FILE: sv/mno_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mno_pkg
// Shared types, constants and pitch table for the MIDI note to oscillator
// block.
// ----------------------------------------------------------------------------
package mno_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // Status nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_SYSTEM   = 4'hF;

    // Pitch constants
    localparam logic [6:0] NOTE_BASE     = 7'd33;
    localparam logic [3:0] NOTES_PER_OCT = 4'd12;
    localparam logic [7:0] DETUNE_CENTER = 8'd128;
    localparam logic [7:0] DETUNE_GAIN   = 8'd106;
    localparam int         OCTAVES       = 8;

    localparam logic [15:0] BASE_PERIOD [12] = '{
        16'd10054, 16'd9490, 16'd8957, 16'd8455, 16'd7980, 16'd7532,
        16'd7109,  16'd6710, 16'd6334, 16'd5978, 16'd5642, 16'd5326
    };

    // One parsed message between the parser and the pitch stage
    typedef struct packed {
        logic       valid;
        logic       gate;
        logic [6:0] note;
    } note_event_t;

endpackage

FILE: sv/mno_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mno_parser
// Running-status MIDI byte parser; registers one note event per completed
// note-on or matching note-off.
// ----------------------------------------------------------------------------
module mno_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    input  logic                 ev_ready,
    output mno_pkg::note_event_t ev
);
    import mno_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  status_reg, status_next;
    logic [6:0]  first_reg, first_next;
    logic [6:0]  held_reg, held_next;
    note_event_t ev_reg, ev_next;
    note_event_t ev_new;
    phase_t      phase_eff;

    // Next parser state and event for the incoming byte
    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        first_next  = first_reg;
        held_next   = held_reg;
        ev_new      = '0;
        phase_eff   = rx_byte[7] ? PH_STATUS : phase_reg;
        if (rx_byte[7:4] != ST_SYSTEM)
        begin
            unique case (phase_eff)
                PH_STATUS:
                begin
                    status_next = rx_byte[7:4];
                    phase_next  = PH_FIRST;
                end
                PH_FIRST:
                begin
                    first_next = rx_byte[6:0];
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    phase_next = PH_FIRST;
                    if (status_reg == ST_NOTE_ON)
                    begin
                        held_next    = first_reg;
                        ev_new.valid = 1'b1;
                        ev_new.gate  = 1'b1;
                        ev_new.note  = first_reg;
                    end
                    else if (status_reg == ST_NOTE_OFF && first_reg == held_reg)
                    begin
                        ev_new.valid = 1'b1;
                        ev_new.gate  = 1'b0;
                        ev_new.note  = first_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // Event register: loads on accept, empties when taken
    always_comb
    begin
        ev_next = ev_reg;
        if (accept)
            ev_next = ev_new;
        else if (ev_ready)
            ev_next.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            status_reg <= ST_NOTE_ON;
            first_reg  <= '0;
            held_reg   <= '0;
            ev_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                status_reg <= status_next;
                first_reg  <= first_next;
                held_reg   <= held_next;
            end
            ev_reg <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

FILE: sv/mno_pitch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mno_pitch
// Octave divider and detuned period top for one note.
// ----------------------------------------------------------------------------
module mno_pitch (
    input  logic [6:0]  note,
    input  logic [7:0]  detune,
    output logic [7:0]  divider,
    output logic [15:0] period
);
    import mno_pkg::*;

    logic [2:0]  octave;
    logic [6:0]  rel_note;
    logic [6:0]  oct_start;
    logic [3:0]  tone_idx;
    logic [15:0] base;
    logic [7:0]  diff;
    logic [13:0] prod;
    logic [15:0] offset;

    // Octave band by compare against band starts
    always_comb
    begin
        octave   = '0;
        rel_note = note - NOTE_BASE;
        for (int k = 1; k < OCTAVES; k++)
        begin
            if (rel_note >= 7'(k * 12))
                octave = 3'(k);
        end
        oct_start = 7'(octave) * 7'(NOTES_PER_OCT);
        tone_idx  = 4'(rel_note - oct_start);
    end

    // Divider and base period; notes below the base give zero
    always_comb
    begin
        if (note < NOTE_BASE)
        begin
            divider = '0;
            base    = '0;
        end
        else
        begin
            divider = (octave == 3'(OCTAVES - 1)) ? 8'd2 : (8'd128 >> octave);
            base    = (tone_idx < NOTES_PER_OCT) ? BASE_PERIOD[tone_idx] : 16'd0;
        end
    end

    // Detune offset, wraps modulo 2^16; distance from center reaches 128
    always_comb
    begin
        diff   = (detune > DETUNE_CENTER) ? (detune - DETUNE_CENTER)
                                          : (DETUNE_CENTER - detune);
        prod   = 14'(diff) * 14'(DETUNE_GAIN);
        offset = 16'(prod >> 7);
        if (detune > DETUNE_CENTER)
            period = base + offset;
        else if (detune < DETUNE_CENTER)
            period = base - offset;
        else
            period = base;
    end

endmodule

FILE: sv/midi_note_to_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_to_oscillator
// One-voice MIDI note parser driving oscillator divider and period values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one received MIDI byte per item
//   on rx_byte. System bytes are dropped; running status is honored.
//   Output channel: out_valid / out_stall carry gate, note_number,
//   divider_integer and period_top. A note-on gives gate 1; a note-off whose
//   note matches the last note-on gives gate 0 with divider and period at 0.
//   Other bytes give no item.
//   Config: cfg_we with cfg_wdata writes the detune register (reset 128).
//   The user must write it only while the block is idle (not enforced).
//   Throughput: one byte per cycle while in_stall is low. A result passes
//   through the parser event register, then the output register holding
//   the pitch lookup.
//   Reset: parser waits for status, running status is note-on, held note 0,
//   both pipeline registers empty.
//   Stall: out_stall holds the output register; the event register behind it
//   keeps taking bytes until it holds one item, then in_stall rises until
//   the output drains.
// ----------------------------------------------------------------------------
module midi_note_to_oscillator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        gate,
    output logic [6:0]  note_number,
    output logic [7:0]  divider_integer,
    output logic [15:0] period_top
);
    import mno_pkg::*;

    logic [7:0]  detune_val_reg;
    note_event_t ev;
    logic        out_load;
    logic        accept;
    logic [7:0]  div_c;
    logic [15:0] per_c;
    logic        out_valid_reg, out_valid_next;
    logic        gate_reg;
    logic [6:0]  note_reg;
    logic [7:0]  div_reg;
    logic [15:0] per_reg;

    // Handshake
    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = ev.valid && !out_load;
    assign accept   = in_valid && !in_stall;

    // Detune register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            detune_val_reg <= DETUNE_CENTER;
        else if (cfg_we)
            detune_val_reg <= cfg_wdata;
    end

    mno_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .ev_ready (out_load),
        .ev       (ev)
    );

    mno_pitch u_pitch (
        .note    (ev.note),
        .detune  (detune_val_reg),
        .divider (div_c),
        .period  (per_c)
    );

    // Output register
    assign out_valid_next = out_load ? ev.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && ev.valid)
        begin
            gate_reg <= ev.gate;
            note_reg <= ev.note;
            div_reg  <= ev.gate ? div_c : 8'd0;
            per_reg  <= ev.gate ? per_c : 16'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign gate            = gate_reg;
    assign note_number     = note_reg;
    assign divider_integer = div_reg;
    assign period_top      = per_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI note to oscillator block. MIDI byte
// streams (directed, then random well-formed messages mixed with noise)
// go in under random sender gaps and receiver stalls. A note tracker
// predicts every gate/divider/period item. Each output item is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import mno_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 95;

    // One oscillator item as seen on the output ports
    typedef struct packed {
        logic        gate;
        logic [6:0]  note;
        logic [7:0]  divider;
        logic [15:0] period;
    } osc_result_t;

    // Tracks parser state and the held note, and queues the oscillator
    // items that the byte stream should produce.
    class note_tracker;
        phase_t      parse_ph;
        logic [3:0]  run_status;
        logic [6:0]  first_note;
        logic [6:0]  held;
        logic [7:0]  detune;
        osc_result_t pending_q[$];
        int          errors;
        int          checked;

        function new();
            parse_ph   = PH_STATUS;
            run_status = ST_NOTE_ON;
            first_note = '0;
            held       = '0;
            detune     = DETUNE_CENTER;
            errors     = 0;
            checked    = 0;
        endfunction

        // Divide by 128 in the lowest octave, then one halving per octave,
        // bottoming out at 2 for the top notes; notes below the table give 0.
        function logic [7:0] octave_div(logic [6:0] n);
            int oct;
            if (n < NOTE_BASE)
                return 8'd0;
            oct = (int'(n) - int'(NOTE_BASE)) / int'(NOTES_PER_OCT);
            if (oct > 6)
                oct = 6;
            return 8'd128 >> oct;
        endfunction

        // Table period shifted by the detune offset, wrapping to 16 bits
        function logic [15:0] period_of(logic [6:0] n);
            int p;
            int d;
            int ctr;
            int gain;
            d    = detune;
            ctr  = DETUNE_CENTER;
            gain = DETUNE_GAIN;
            if (n >= NOTE_BASE)
                p = BASE_PERIOD[(int'(n) - int'(NOTE_BASE)) % int'(NOTES_PER_OCT)];
            else
                p = 0;
            if (d > ctr)
                p += (gain * (d - ctr)) >>> 7;
            else if (d < ctr)
                p -= (gain * (ctr - d)) >>> 7;
            return p[15:0];
        endfunction

        // Called for every accepted input item
        function void note_byte(logic [7:0] b);
            osc_result_t r;
            if (b[7:4] == ST_SYSTEM)
                return;
            if (b[7])
                parse_ph = PH_STATUS;
            case (parse_ph)
                PH_STATUS:
                begin
                    run_status = b[7:4];
                    parse_ph   = PH_FIRST;
                    return;
                end
                PH_FIRST:
                begin
                    first_note = b[6:0];
                    parse_ph   = PH_SECOND;
                    return;
                end
                PH_SECOND:
                    parse_ph = PH_FIRST;
                default:
                begin
                    parse_ph = PH_FIRST;
                    return;
                end
            endcase
            if (run_status == ST_NOTE_ON)
            begin
                held      = first_note;
                r.gate    = 1'b1;
                r.note    = first_note;
                r.divider = octave_div(first_note);
                r.period  = period_of(first_note);
                pending_q.push_back(r);
            end
            else if (run_status == ST_NOTE_OFF && first_note == held)
            begin
                r        = '0;
                r.note   = first_note;
                pending_q.push_back(r);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] error: %s", $time, what);
        endtask

        // Called for every accepted output item
        task check_result(osc_result_t got);
            osc_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item: gate %0b note %0d",
                                          got.gate, got.note));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.gate !== want.gate)
                report_mismatch($sformatf("gate got %0b want %0b (note %0d)",
                                          got.gate, want.gate, want.note));
            if (got.note !== want.note)
                report_mismatch($sformatf("note_number got %0d want %0d",
                                          got.note, want.note));
            if (got.divider !== want.divider)
                report_mismatch($sformatf("divider_integer got %0d want %0d (note %0d)",
                                          got.divider, want.divider, want.note));
            if (got.period !== want.period)
                report_mismatch($sformatf("period_top got %0d want %0d (note %0d)",
                                          got.period, want.period, want.note));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        out_valid;
    logic        out_stall;
    logic        gate;
    logic [6:0]  note_number;
    logic [7:0]  divider_integer;
    logic [15:0] period_top;

    note_tracker tracker;
    int          cycles = 0;
    int          bytes_sent;
    int          settings_used;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          long_hold_req;

    midi_note_to_oscillator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .gate            (gate),
        .note_number     (note_number),
        .divider_integer (divider_integer),
        .period_top      (period_top)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({gate, note_number, divider_integer, period_top});
    end

    // Receiver stall: short random bursts, rare long ones, one long hold
    initial
    begin
        int stall_left;
        int r;
        bit hold_taken;
        out_stall  = 1'b0;
        stall_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !rx_quiet)
            begin
                r = $urandom_range(0, 99);
                if (r >= 97)
                    stall_left = $urandom_range(10, 30);
                else if (r >= 75)
                    stall_left = $urandom_range(1, 3);
            end
            out_stall = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly notes inside the table, some below it
    function logic [7:0] pick_note();
        if ($urandom_range(0, 99) < 15)
            return 8'($urandom_range(0, 32));
        return 8'($urandom_range(33, 127));
    endfunction

    function logic [7:0] pick_data();
        return 8'($urandom_range(0, 127));
    endfunction

    // Offer one item, hold it until accepted; returns at a falling edge
    task put_byte(logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            rx_byte  = 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task put_status(logic [3:0] nib);
        logic [3:0] ch;
        ch = 4'($urandom_range(0, 15));
        put_byte({nib, ch});
    endtask

    // Random traffic: mostly complete messages, some noise and broken ones
    task random_traffic(int n);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                put_status(ST_NOTE_ON);
                put_byte(pick_note());
                put_byte(pick_data());
            end
            else if (r < 50)
            begin
                // running status pair
                put_byte(pick_note());
                put_byte(pick_data());
            end
            else if (r < 70)
            begin
                put_status(ST_NOTE_OFF);
                put_byte(($urandom_range(0, 3) != 0) ? {1'b0, tracker.held} : pick_note());
                put_byte(pick_data());
            end
            else if (r < 78)
            begin
                put_status(4'($urandom_range(10, 14)));
                put_byte(pick_data());
                put_byte(pick_data());
            end
            else if (r < 85)
                put_byte(8'($urandom_range(240, 255)));
            else if (r < 92)
            begin
                // truncated message
                put_status($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF);
                put_byte(pick_note());
            end
            else
                put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task wait_drained();
        in_valid = 1'b0;
        while (tracker.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task write_detune(logic [7:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we         = 1'b0;
        tracker.detune = v;
        settings_used++;
    endtask

    // Directed stream: stray data first, system bytes, note extremes,
    // running status, matching/non-matching note-off, other status
    logic [7:0] directed_bytes [] = '{
        8'h45, 8'h3C, 8'h40,            // data before any status, silent
        8'hF8,                          // system byte
        8'h90, 8'h00, 8'h7F,            // note 0
        8'h20, 8'h00,                   // note 32, running status
        8'h21, 8'h40,                   // note 33
        8'h7F, 8'h7F,                   // note 127
        8'h2C, 8'hFE, 8'h10,            // system byte inside a message
        8'h80, 8'h2C, 8'h00,            // note-off, matches
        8'h85, 8'h2D, 8'h00,            // note-off, no match
        8'h8F, 8'h2C, 8'h00,            // note-off while silent
        8'hB3, 8'h07, 8'h64,            // other status
        8'h9F, 8'h45,                   // truncated
        8'h92, 8'h45, 8'h01             // note 69
    };

    logic [7:0] detune_plan [6];

    // Main sequence
    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        settings_used = 1;
        detune_plan   = '{8'd0, 8'd255, 8'd127, 8'd129, 8'($urandom_range(0, 255)), 8'd128};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset detune
        foreach (directed_bytes[i])
            put_byte(directed_bytes[i]);
        wait_drained();

        // Random phases, one per detune setting
        foreach (detune_plan[i])
        begin
            write_detune(detune_plan[i]);
            if (i == 1)
            begin
                tx_quiet      = 1'b1;
                long_hold_req = 1'b1;
            end
            if (i == 3)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            random_traffic(PHASE_BYTES);
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
            wait_drained();
        end

        $display("Sent %0d MIDI bytes under %0d detune settings (0, 127..129, 255, random).",
                 bytes_sent, settings_used);
        $display("Checked %0d oscillator items, %0d errors.", tracker.checked, tracker.errors);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
